>>> design/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude block
// Command and status bundles between controller and datapath, register codes.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int unsigned PIX_W     = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 13;
	localparam int unsigned IMG_W_W   = 12;
	localparam int unsigned IMG_H_W   = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic shift;
		logic grad;
		logic square;
		logic sum;
		logic root_step;
		logic load_out;
		logic cfg_we;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit;
		logic root_last;
		logic out_free;
	} status_t;

endpackage

>>> design/sobel_edge_magnitude_3x3.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3: 3x3 Sobel gradient magnitude on a pixel stream
// Raster-order pixels in, rounded and saturated edge magnitude out.
// ----------------------------------------------------------------------------
// Pixels enter one at a time in raster order; each interior output is
// round(sqrt(Gx*Gx + Gy*Gy)) saturated at 255, border pixels pass unchanged.
// Results lag by one row plus one pixel, so after the last pixel of a frame
// the user sends flush words (width + 1 of them) until the word with
// frame_last comes out. An item with a result goes through the gradient,
// squaring, sum and bit-serial root search steps, the root search trying one
// result bit per cycle through a single 8x8 multiplier. A finished word waits
// in the output register while the next item is taken. Writes of the width
// or height register restart the frame.
module sobel_edge_magnitude_3x3 #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic [sem_pkg::PIX_W-1:0]      pixel_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sem_pkg::PIX_W-1:0]      pixel_out,
	output logic                           frame_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sem_pkg::CFG_DAT_W-1:0]  cfg_data
);

	sem_pkg::cmd_t    cmd;
	sem_pkg::status_t status;

	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_valid (cfg_valid),
		.status    (status),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready)
	);

	sem_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.command    (command),
		.pixel_in   (pixel_in),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_out  (pixel_out),
		.frame_last (frame_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

	// Only one datapath phase is commanded in any cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.shift, cmd.grad, cmd.square, cmd.sum,
			cmd.root_step, cmd.load_out}))
		else $error("more than one datapath phase commanded");

	// An accepted item keeps the input side busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again while an item is in work");

	// A result is never loaded over a word that is still held.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid || !out_stall)
		else $error("output word overwritten while stalled");

	// A new output word follows its load.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded word not presented");

endmodule

>>> design/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl: controller of the Sobel edge magnitude block
// Sequences accept, window update, gradient, squaring, root search and output.
// ----------------------------------------------------------------------------
module sem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              cfg_valid,
	input  sem_pkg::status_t  status,
	output sem_pkg::cmd_t     cmd,
	output logic              in_stall,
	output logic              cfg_ready
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SHIFT = 7'b0000010,
		ST_GRAD  = 7'b0000100,
		ST_SQR   = 7'b0001000,
		ST_SUM   = 7'b0010000,
		ST_ROOT  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.cfg_we = cfg_valid;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = status.emit ? ST_GRAD : ST_IDLE;
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = ST_SQR;
			end
			ST_SQR: begin
				cmd.square = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (status.root_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/sem_dp.sv
// ----------------------------------------------------------------------------
// sem_dp: datapath of the Sobel edge magnitude block
// Line buffers, 3x3 window, position counters, gradient and rounded root.
// ----------------------------------------------------------------------------
module sem_dp #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sem_pkg::cmd_t                       cmd,
	output sem_pkg::status_t                    status,
	input  logic                                command,
	input  logic [sem_pkg::PIX_W-1:0]           pixel_in,
	input  logic [sem_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sem_pkg::CFG_DAT_W-1:0]       cfg_data,
	output logic [sem_pkg::PIX_W-1:0]           pixel_out,
	output logic                                frame_last,
	output logic                                out_valid,
	input  logic                                out_stall
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = CW + 1;
	localparam int unsigned WH = $clog2(MAX_HEIGHT) + 1;

	logic [sem_pkg::IMG_W_W-1:0] width_q;
	logic [sem_pkg::IMG_H_W-1:0] height_q;
	logic [WW-1:0] in_col_q, out_col_q;
	logic [WH-1:0] in_row_q, out_row_q;
	logic          draining_q;
	logic          cmd_q;
	logic [7:0]    pix_q;
	logic [7:0]    win_q [9];
	logic [7:0]    upper_rd, middle_rd;
	logic          border_q, last_q;
	logic signed [10:0] gx_q, gy_q;
	logic [20:0]   gx2_q, gy2_q;
	logic [21:0]   s_q;
	logic [7:0]    root_q;
	logic [2:0]    bit_q;
	logic          out_valid_q;

	logic [31:0]   w32, h32;
	logic [WW-1:0] eff_w, x_cl, x_nx, ocol_nx;
	logic [WH-1:0] eff_h, y_nx, orow_nx;
	logic [7:0]    val;
	logic          ignore, emit, border, last;
	logic [10:0]   gx_sum, gy_sum;
	logic [20:0]   gx_sq, gy_sq;
	logic [7:0]    cand;
	logic [15:0]   cand_prod;

	// Register values out of range act as 1 or as the largest supported size.
	always_comb begin
		w32 = 32'(width_q);
		h32 = 32'(height_q);
		if (w32 == 32'd0) begin
			w32 = 32'd1;
		end
		if (w32 > MAX_WIDTH) begin
			w32 = MAX_WIDTH;
		end
		if (h32 == 32'd0) begin
			h32 = 32'd1;
		end
		if (h32 > MAX_HEIGHT) begin
			h32 = MAX_HEIGHT;
		end
		eff_w = w32[WW-1:0];
		eff_h = h32[WH-1:0];
	end

	always_comb begin
		x_cl = (in_col_q >= eff_w) ? eff_w - WW'(1) : in_col_q;
		val  = draining_q ? 8'd0 : pix_q;
		// A flush before the frame end and a pixel while draining are dropped.
		ignore = (cmd_q == sem_pkg::CMD_FLUSH) != draining_q;
		emit   = (in_row_q >= WH'(2)) || (in_row_q == WH'(1) && x_cl >= WW'(1));
		x_nx   = x_cl + WW'(1);
		y_nx   = in_row_q;
		if (x_nx >= eff_w) begin
			x_nx = '0;
			y_nx = in_row_q + WH'(1);
		end
		border = (out_row_q == '0) || (out_row_q >= eff_h - WH'(1)) ||
			(out_col_q == '0) || (out_col_q >= eff_w - WW'(1));
		last   = (out_row_q >= eff_h - WH'(1)) && (out_col_q >= eff_w - WW'(1));
		ocol_nx = out_col_q + WW'(1);
		orow_nx = out_row_q;
		if (ocol_nx >= eff_w) begin
			ocol_nx = '0;
			orow_nx = out_row_q + WH'(1);
		end
	end

	assign status.emit = !ignore && emit;

	sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (cmd.shift && !ignore),
		.waddr (x_cl[CW-1:0]),
		.wdata (middle_rd),
		.re    (cmd.accept),
		.raddr (x_cl[CW-1:0]),
		.rdata (upper_rd)
	);

	sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (cmd.shift && !ignore),
		.waddr (x_cl[CW-1:0]),
		.wdata (val),
		.re    (cmd.accept),
		.raddr (x_cl[CW-1:0]),
		.rdata (middle_rd)
	);

	// Configuration, position counters and window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= sem_pkg::WIDTH_RESET;
			height_q   <= sem_pkg::HEIGHT_RESET;
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			draining_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.cfg_we) begin
			if (cfg_index == sem_pkg::CFG_IMAGE_WIDTH) begin
				width_q <= cfg_data[sem_pkg::IMG_W_W-1:0];
			end
			if (cfg_index == sem_pkg::CFG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end
			if (cfg_index == sem_pkg::CFG_IMAGE_WIDTH ||
				cfg_index == sem_pkg::CFG_IMAGE_HEIGHT) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				draining_q <= 1'b0;
			end
		end else if (cmd.shift && !ignore) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= upper_rd;
			win_q[5] <= middle_rd;
			win_q[8] <= val;
			in_col_q <= x_nx;
			in_row_q <= y_nx;
			if (!draining_q && in_row_q == eff_h - WH'(1) && x_cl == eff_w - WW'(1)) begin
				draining_q <= 1'b1;
			end
			if (emit) begin
				if (last) begin
					// The final word of the frame restarts all positions.
					in_col_q   <= '0;
					in_row_q   <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					draining_q <= 1'b0;
				end else begin
					out_col_q <= ocol_nx;
					out_row_q <= orow_nx;
				end
			end
		end
	end

	always_comb begin
		gx_sum = (11'(win_q[2]) + {2'b0, win_q[5], 1'b0} + 11'(win_q[8])) -
			(11'(win_q[0]) + {2'b0, win_q[3], 1'b0} + 11'(win_q[6]));
		gy_sum = (11'(win_q[6]) + {2'b0, win_q[7], 1'b0} + 11'(win_q[8])) -
			(11'(win_q[0]) + {2'b0, win_q[1], 1'b0} + 11'(win_q[2]));
		gx_sq  = gx_q * gx_q;
		gy_sq  = gy_q * gy_q;
		cand   = root_q | (8'd1 << bit_q);
		cand_prod = cand * (cand - 8'd1);
	end

	assign status.root_last = (bit_q == 3'd0);

	// Item payload, gradients and the bit-serial rounded root.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= command;
			pix_q <= pixel_in;
		end
		if (cmd.shift) begin
			border_q <= border;
			last_q   <= last;
		end
		if (cmd.grad) begin
			gx_q <= $signed(gx_sum);
			gy_q <= $signed(gy_sum);
		end
		if (cmd.square) begin
			gx2_q <= gx_sq;
			gy2_q <= gy_sq;
		end
		if (cmd.sum) begin
			s_q    <= 22'(gx2_q) + 22'(gy2_q);
			root_q <= '0;
			bit_q  <= 3'd7;
		end
		// Largest k with k*k - k < s; this also saturates at 255.
		if (cmd.root_step) begin
			if (22'(cand_prod) < s_q) begin
				root_q <= cand;
			end
			bit_q <= bit_q - 3'd1;
		end
		if (cmd.load_out) begin
			pixel_out  <= border_q ? win_q[4] : root_q;
			frame_last <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

>>> test/tb_sobel_edge_magnitude_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_3x3: self-checking bench for the Sobel magnitude block
// Streams frames of several sizes through the block with random gaps and
// output stalls, predicts every result word and compares it with the output.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_3x3;

	localparam int unsigned LINE_MAX   = 2048;
	localparam int unsigned ROWS_MAX   = 4096;
	localparam int unsigned SETTLE_CYC = 40;
	localparam int unsigned DOG_LIMIT  = 3000;
	localparam int unsigned NUM_ITEMS  = 1400;

	typedef struct packed {
		logic [sem_pkg::PIX_W-1:0] pix;
		logic                      last;
	} edge_word_t;

	typedef struct {
		logic       cmd;
		logic [7:0] pix;
		bit         chk;
		edge_word_t want;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          command;
	logic [sem_pkg::PIX_W-1:0]     pixel_in;
	logic                          out_valid;
	logic                          out_stall;
	logic [sem_pkg::PIX_W-1:0]     pixel_out;
	logic                          frame_last;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [sem_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sem_pkg::CFG_DAT_W-1:0] cfg_data;

	sobel_edge_magnitude_3x3 dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_out(pixel_out), .frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow state of the block.
	logic [7:0]  row_up [LINE_MAX];
	logic [7:0]  row_mid [LINE_MAX];
	logic [7:0]  win [9];
	int unsigned img_w, img_h;
	int unsigned in_x, in_y, out_x, out_y;
	bit          draining;

	edge_word_t  pending_q[$];
	stim_row_t   dir_tab[$];
	bit          tab_chk;
	edge_word_t  tab_want;
	int unsigned mismatches;
	int unsigned sent;
	int unsigned idle_cyc;
	bit          calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_width(input int unsigned v);
		return (v == 0) ? 1 : ((v > LINE_MAX) ? LINE_MAX : v);
	endfunction

	function automatic int unsigned eff_height(input int unsigned v);
		return (v == 0) ? 1 : ((v > ROWS_MAX) ? ROWS_MAX : v);
	endfunction

	function automatic void restart_frame();
		in_x = 0;
		in_y = 0;
		out_x = 0;
		out_y = 0;
		draining = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [sem_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned val);
		if (idx == sem_pkg::CFG_IMAGE_WIDTH) begin
			img_w = val & 12'hFFF;
			restart_frame();
		end else if (idx == sem_pkg::CFG_IMAGE_HEIGHT) begin
			img_h = val & 13'h1FFF;
			restart_frame();
		end
	endfunction

	// Advances the shadow state by one accepted word; returns 1 when it yields a result.
	function automatic bit sobel_step(input logic cmd, input logic [7:0] pin,
			output edge_word_t res);
		int unsigned w, h, x, y, s, k;
		logic [7:0]  v;
		int          gx, gy;
		bit          emit, border, last;
		w = eff_width(img_w);
		h = eff_height(img_h);
		res = '0;
		if ((cmd == sem_pkg::CMD_FLUSH) != draining)
			return 1'b0;
		v = draining ? 8'd0 : pin;
		x = (in_x >= w) ? w - 1 : in_x;
		y = in_y;
		for (int r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = row_up[x];
		win[5] = row_mid[x];
		win[8] = v;
		row_up[x] = row_mid[x];
		row_mid[x] = v;
		emit = (y >= 2) || (y == 1 && x >= 1);
		if (!draining && y == h - 1 && x == w - 1)
			draining = 1'b1;
		x++;
		if (x >= w) begin
			x = 0;
			y++;
		end
		in_x = x;
		in_y = y;
		if (!emit)
			return 1'b0;
		border = (out_y == 0) || (out_y >= h - 1) || (out_x == 0) || (out_x >= w - 1);
		last = (out_y >= h - 1) && (out_x >= w - 1);
		if (border) begin
			res.pix = win[4];
		end else begin
			gx = (win[2] + 2 * win[5] + win[8]) - (win[0] + 2 * win[3] + win[6]);
			gy = (win[6] + 2 * win[7] + win[8]) - (win[0] + 2 * win[1] + win[2]);
			s = gx * gx + gy * gy;
			// Rounded root: the smallest k with s <= k*k + k, clipped at 255.
			k = 0;
			while (k < 255 && s > k * k + k)
				k++;
			res.pix = k[7:0];
		end
		res.last = last;
		if (last) begin
			restart_frame();
		end else begin
			out_x++;
			if (out_x >= w) begin
				out_x = 0;
				out_y++;
			end
		end
		return 1'b1;
	endfunction

	function automatic void report(input string what, input edge_word_t want,
			input edge_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%t %s: expected pix %0d last %0b, got pix %0d last %0b",
				$realtime, what, want.pix, want.last, got.pix, got.last);
	endfunction

	// Prediction on accepted input words, checking on accepted output words.
	always @(posedge clk) begin
		edge_word_t res, got;
		bit         made;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				made = sobel_step(command, pixel_in, res);
				if (tab_chk && (!made || res !== tab_want))
					report("table row", tab_want, res);
				if (made)
					pending_q.push_back(res);
			end
			if (out_valid && !out_stall) begin
				got.pix = pixel_out;
				got.last = frame_last;
				if (pending_q.size() == 0) begin
					report("unexpected word", '0, got);
				end else begin
					res = pending_q.pop_front();
					if (got !== res)
						report("result word", res, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || calm)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 12);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= DOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Entered and left at a falling edge.
	task automatic send_word(input logic cmd, input logic [7:0] pix);
		if (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pixel_in <= pix;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	// Takes cfg_valid low again after the write so that writes never overlap.
	task automatic write_reg(input logic [sem_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[sem_pkg::CFG_DAT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Waits for every expected word, then lets a word without result finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_pixel();
		if ($urandom_range(99) < 20)
			return $urandom_range(1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(255));
	endfunction

	task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned cut);
		int unsigned n;
		settle();
		write_reg(sem_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(sem_pkg::CFG_IMAGE_HEIGHT, h);
		n = eff_width(w) * eff_height(h);
		if (cut != 0 && cut < n)
			n = cut;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) < 4)
				send_word(sem_pkg::CMD_FLUSH, rand_pixel());
			send_word(sem_pkg::CMD_PIXEL, rand_pixel());
		end
		while (draining) begin
			if ($urandom_range(99) < 4)
				send_word(sem_pkg::CMD_PIXEL, rand_pixel());
			send_word(sem_pkg::CMD_FLUSH, rand_pixel());
		end
	endtask

	function automatic void add_row(input logic cmd, input logic [7:0] pix, input bit chk,
			input logic [7:0] wpix, input logic wlast);
		stim_row_t r;
		r.cmd = cmd;
		r.pix = pix;
		r.chk = chk;
		r.want.pix = wpix;
		r.want.last = wlast;
		dir_tab.push_back(r);
	endfunction

	initial begin
		int unsigned w, h;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = sem_pkg::CMD_PIXEL;
		pixel_in = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = sem_pkg::CFG_IMAGE_WIDTH;
		cfg_data = '0;
		tab_chk = 1'b0;
		tab_want = '0;
		mismatches = 0;
		sent = 0;
		idle_cyc = 0;
		calm = 1'b0;
		img_w = 32'(sem_pkg::WIDTH_RESET);
		img_h = 32'(sem_pkg::HEIGHT_RESET);
		foreach (row_up[i]) begin
			row_up[i] = '0;
			row_mid[i] = '0;
		end
		foreach (win[i])
			win[i] = '0;
		restart_frame();

		// 3x3 frame: dark left and middle columns, bright right column.
		add_row(sem_pkg::CMD_FLUSH, 8'd9, 1'b0, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd255, 1'b0, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd0, 1'b1, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd255, 1'b1, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd0, 1'b1, 8'd255, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd0, 1'b1, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_PIXEL, 8'd255, 1'b1, 8'd255, 1'b0);
		// A pixel offered while the frame drains is dropped.
		add_row(sem_pkg::CMD_PIXEL, 8'd77, 1'b0, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_FLUSH, 8'd0, 1'b1, 8'd255, 1'b0);
		add_row(sem_pkg::CMD_FLUSH, 8'd255, 1'b1, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_FLUSH, 8'd0, 1'b1, 8'd0, 1'b0);
		add_row(sem_pkg::CMD_FLUSH, 8'd0, 1'b1, 8'd255, 1'b1);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(sem_pkg::CFG_IMAGE_WIDTH, 3);
		write_reg(sem_pkg::CFG_IMAGE_HEIGHT, 3);
		foreach (dir_tab[i]) begin
			tab_chk = dir_tab[i].chk;
			tab_want = dir_tab[i].want;
			send_word(dir_tab[i].cmd, dir_tab[i].pix);
		end
		tab_chk = 1'b0;

		// Oversized width and height words (both cut short), zero sizes, a small frame.
		run_frame(4095, 1, 40);
		run_frame(0, 0, 0);
		run_frame(4, 8191, 30);
		run_frame(3, 3, 0);

		while (sent < NUM_ITEMS) begin
			calm = (sent >= 500 && sent < 800);
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			if ($urandom_range(99) < 5)
				w = 0;
			if ($urandom_range(99) < 5)
				h = 0;
			run_frame(w, h, ($urandom_range(99) < 10) ? $urandom_range(1, 20) : 0);
		end
		calm = 1'b0;

		settle();
		if (mismatches == 0 && pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
design/sem_pkg.sv
design/sem_ram.sv
design/sem_ctrl.sv
design/sem_dp.sv
design/sobel_edge_magnitude_3x3.sv
test/tb_sobel_edge_magnitude_3x3.sv
